FILE: hw/rtl/vcfp_pkg.sv
// shared types and constants for the velocity command frame parser
package vcfp_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN   = 15;
   localparam int unsigned HEADER_LEN  = 2;
   localparam int unsigned PAYLOAD_LEN = FRAME_LEN - HEADER_LEN - 1;
   localparam int unsigned POS_W       = $clog2(FRAME_LEN);

   localparam logic [7:0] SYNC_BYTE = 8'hFF;

   localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_LEN);
   localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(FRAME_LEN - 1);

   typedef logic [7:0] byte_type;
   typedef logic [31:0] word_type;
   typedef logic [POS_W-1:0] pos_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_BAD_HEADER   = 2'd1,
      ST_BAD_CHECKSUM = 2'd2
   } status_type;

   // one finished frame from the frame tracker
   typedef struct packed {
      logic       done;
      status_type status;
      word_type   vx_bits;
      word_type   vy_bits;
      word_type   wz_bits;
   } frame_result_type;

endpackage

FILE: hw/rtl/vcfp_if.sv
// valid/ready channel interfaces for frame bytes and parsed commands

interface vcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface vcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] vx_bits;
   logic [31:0] vy_bits;
   logic [31:0] wz_bits;

   modport source (output valid, output status, output vx_bits, output vy_bits,
                   output wz_bits, input ready);
   modport sink (input valid, input status, input vx_bits, input vy_bits,
                 input wz_bits, output ready);
endinterface

FILE: hw/rtl/velocity_command_frame_parser.sv
// top level of the velocity command frame parser
// Takes one frame byte per beat on req, with first_byte marking byte 0 of a
// 15-byte frame (two 0xFF sync bytes, three little-endian 32-bit words for
// x, y and angular velocity, and an xor checksum of the twelve payload
// bytes). On the checksum byte one beat leaves on rsp with the status and
// the three words, which read zero unless the status is ok; a bad header
// wins over a bad checksum. A first_byte flag inside a frame drops the
// partial frame and restarts. Bytes are taken every cycle while ready is
// high: each beat goes through an input register, one pass of frame tracking
// logic and the result register, so a result is offered on rsp once its
// checksum byte reaches the result register. Ready drops only while the input
// register is full behind a result beat that rsp has not taken.
module velocity_command_frame_parser (
   input  logic          clock,
   input  logic          reset,
   vcfp_req_if.sink      req,
   vcfp_rsp_if.source    rsp
);

   logic                       in_valid_ff;
   vcfp_pkg::byte_type         in_byte_ff;
   logic                       in_first_ff;
   logic                       out_valid_ff;
   vcfp_pkg::status_type       out_status_ff;
   vcfp_pkg::word_type         out_vx_ff;
   vcfp_pkg::word_type         out_vy_ff;
   vcfp_pkg::word_type         out_wz_ff;
   logic                       stage_adv;
   logic                       fire;
   vcfp_pkg::frame_result_type result;

   // pipeline moves when the result register is free or draining
   assign stage_adv = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || stage_adv;
   assign fire      = in_valid_ff && stage_adv;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff  <= req.data_byte;
         in_first_ff <= req.first_byte;
      end
   end

   vcfp_frame_track u_track (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .result     (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_adv) begin
         out_valid_ff <= result.done;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv && result.done) begin
         out_status_ff <= result.status;
         out_vx_ff     <= result.vx_bits;
         out_vy_ff     <= result.vy_bits;
         out_wz_ff     <= result.wz_bits;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.status  = out_status_ff;
   assign rsp.vx_bits = out_vx_ff;
   assign rsp.vy_bits = out_vy_ff;
   assign rsp.wz_bits = out_wz_ff;

endmodule

FILE: hw/rtl/vcfp_frame_track.sv
// frame position, header check, running xor and payload shift line
module vcfp_frame_track (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  vcfp_pkg::byte_type        data_byte,
   input  logic                      first_byte,
   output vcfp_pkg::frame_result_type result
);

   vcfp_pkg::pos_type  pos_ff, pos_in;
   logic               in_frame_ff, in_frame_in;
   logic               header_good_ff, header_good_in;
   vcfp_pkg::byte_type xor_ff, xor_in;
   vcfp_pkg::byte_type store_ff [vcfp_pkg::PAYLOAD_LEN];

   // state as seen by this beat, after a possible restart
   vcfp_pkg::pos_type  eff_pos;
   logic               eff_in_frame;
   logic               eff_header_good;
   vcfp_pkg::byte_type eff_xor;
   logic               in_header;
   logic               in_payload;
   logic               at_checksum;

   assign eff_in_frame    = first_byte | in_frame_ff;
   assign eff_pos         = first_byte ? '0 : pos_ff;
   assign eff_header_good = first_byte | header_good_ff;
   assign eff_xor         = first_byte ? '0 : xor_ff;

   assign in_header   = eff_in_frame && (eff_pos < vcfp_pkg::POS_PAYLOAD);
   assign in_payload  = eff_in_frame && (eff_pos >= vcfp_pkg::POS_PAYLOAD)
                        && (eff_pos < vcfp_pkg::POS_CHECKSUM);
   assign at_checksum = eff_in_frame && (eff_pos >= vcfp_pkg::POS_CHECKSUM);

   // next state
   always_comb begin
      pos_in         = eff_pos;
      in_frame_in    = eff_in_frame;
      header_good_in = eff_header_good;
      xor_in         = eff_xor;
      if (in_header) begin
         header_good_in = eff_header_good && (data_byte == vcfp_pkg::SYNC_BYTE);
         pos_in         = eff_pos + 1'b1;
      end else if (in_payload) begin
         xor_in = eff_xor ^ data_byte;
         pos_in = eff_pos + 1'b1;
      end else if (at_checksum) begin
         in_frame_in = 1'b0;
         pos_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         in_frame_ff    <= 1'b0;
         header_good_ff <= 1'b0;
         xor_ff         <= '0;
      end else if (fire) begin
         pos_ff         <= pos_in;
         in_frame_ff    <= in_frame_in;
         header_good_ff <= header_good_in;
         xor_ff         <= xor_in;
      end
   end

   // payload bytes shift in at the top, byte 2 ends at entry 0
   always_ff @(posedge clock) begin
      if (fire && in_payload) begin
         for (int i = 0; i < vcfp_pkg::PAYLOAD_LEN - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[vcfp_pkg::PAYLOAD_LEN-1] <= data_byte;
      end
   end

   // result on the checksum byte
   always_comb begin
      result         = '0;
      result.done    = fire && at_checksum;
      result.status  = vcfp_pkg::ST_OK;
      if (!eff_header_good) begin
         result.status = vcfp_pkg::ST_BAD_HEADER;
      end else if (data_byte != eff_xor) begin
         result.status = vcfp_pkg::ST_BAD_CHECKSUM;
      end else begin
         result.vx_bits = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
         result.vy_bits = {store_ff[7], store_ff[6], store_ff[5], store_ff[4]};
         result.wz_bits = {store_ff[11], store_ff[10], store_ff[9], store_ff[8]};
      end
   end

endmodule

FILE: test/tb_velocity_command_frame_parser.sv
// self-checking testbench for the velocity command frame parser
module tb_velocity_command_frame_parser;

   localparam int STIM_TARGET = 850;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;

   // one frame byte waiting to be driven
   typedef struct {
      vcfp_pkg::byte_type data;
      logic               first;
   } frame_byte_type;

   // one parsed command as it leaves on rsp
   typedef struct {
      vcfp_pkg::status_type status;
      vcfp_pkg::word_type   vx;
      vcfp_pkg::word_type   vy;
      vcfp_pkg::word_type   wz;
   } command_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vcfp_req_if req_bus ();
   vcfp_rsp_if rsp_bus ();

   velocity_command_frame_parser DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   frame_byte_type     byte_queue[$];
   command_beat_type   pending_commands[$];
   int                 stim_items = 0;
   int                 bad_beats = 0;
   int                 gap_left;
   int                 stall_left;
   int                 quiet_cycles;

   // frame tracker state mirrored from the block
   int                 frame_pos;
   logic               frame_open;
   logic               sync_ok;
   vcfp_pkg::byte_type run_xor;
   logic [95:0]        payload_bytes;

   always #5 clock = ~clock;

   // idling only in the bulk of the run, with one calm stretch in the middle
   function automatic logic idle_allowed();
      int left;
      left = byte_queue.size();
      return left > 120 && !(left inside {[400:500]});
   endfunction

   // xor of the twelve payload bytes
   function automatic vcfp_pkg::byte_type payload_xor(input logic [95:0] pay);
      vcfp_pkg::byte_type acc;
      acc = '0;
      for (int k = 0; k < vcfp_pkg::PAYLOAD_LEN; k++) acc ^= pay[8*k +: 8];
      return acc;
   endfunction

   // random payload leaning toward extreme byte values
   function automatic logic [95:0] random_payload();
      logic [95:0] pay;
      for (int k = 0; k < vcfp_pkg::PAYLOAD_LEN; k++) begin
         case ($urandom_range(0, 7))
            0: pay[8*k +: 8] = 8'h00;
            1: pay[8*k +: 8] = 8'hFF;
            2: pay[8*k +: 8] = 8'h80;
            3: pay[8*k +: 8] = 8'h7F;
            default: pay[8*k +: 8] = vcfp_pkg::byte_type'($urandom_range(0, 255));
         endcase
      end
      return pay;
   endfunction

   task automatic add_byte(input vcfp_pkg::byte_type b, input logic first,
                           input logic counted);
      frame_byte_type fb;
      fb.data = b;
      fb.first = first;
      byte_queue.push_back(fb);
      if (counted) stim_items++;
   endtask

   // queue the first upto bytes of a frame
   task automatic add_frame(input vcfp_pkg::byte_type h0, input vcfp_pkg::byte_type h1,
                            input logic [95:0] pay, input vcfp_pkg::byte_type chk,
                            input int upto);
      for (int k = 0; k < upto; k++) begin
         if (k == 0) add_byte(h0, 1'b1, 1'b1);
         else if (k == 1) add_byte(h1, 1'b0, 1'b1);
         else if (k < vcfp_pkg::FRAME_LEN - 1) add_byte(pay[8*(k-2) +: 8], 1'b0, 1'b1);
         else add_byte(chk, 1'b0, 1'b1);
      end
   endtask

   // advance the frame tracker by one accepted byte
   function automatic void decode_frame_byte(input vcfp_pkg::byte_type b, input logic first,
                                             output logic emits,
                                             output command_beat_type res);
      emits = 1'b0;
      res = '{vcfp_pkg::ST_OK, '0, '0, '0};
      if (first) begin
         frame_open = 1'b1;
         frame_pos = 0;
         sync_ok = 1'b1;
         run_xor = '0;
      end
      if (frame_open) begin
         if (frame_pos < vcfp_pkg::HEADER_LEN) begin
            if (b != vcfp_pkg::SYNC_BYTE) sync_ok = 1'b0;
            frame_pos++;
         end else if (frame_pos < vcfp_pkg::FRAME_LEN - 1) begin
            payload_bytes[8*(frame_pos-vcfp_pkg::HEADER_LEN) +: 8] = b;
            run_xor ^= b;
            frame_pos++;
         end else begin
            frame_open = 1'b0;
            frame_pos = 0;
            emits = 1'b1;
            if (!sync_ok) begin
               res.status = vcfp_pkg::ST_BAD_HEADER;
            end else if (b != run_xor) begin
               res.status = vcfp_pkg::ST_BAD_CHECKSUM;
            end else begin
               res.vx = payload_bytes[31:0];
               res.vy = payload_bytes[63:32];
               res.wz = payload_bytes[95:64];
            end
         end
      end
   endfunction

   // byte driver fed from the queue
   always @(posedge clock) begin
      frame_byte_type fb;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= $urandom_range(0, 9);
         end else if (byte_queue.size() > 0) begin
            fb = byte_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= fb.data;
            req_bus.first_byte <= fb.first;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result back pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_bus.ready && idle_allowed() && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: predict on accepted bytes, check accepted results
   always @(posedge clock) begin
      logic             emits;
      command_beat_type want;
      command_beat_type got;
      if (reset) begin
         frame_pos = 0;
         frame_open = 1'b0;
         sync_ok = 1'b0;
         run_xor = '0;
         payload_bytes = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_frame_byte(req_bus.data_byte, req_bus.first_byte, emits, want);
            if (emits) pending_commands.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status = vcfp_pkg::status_type'(rsp_bus.status);
            got.vx = rsp_bus.vx_bits;
            got.vy = rsp_bus.vy_bits;
            got.wz = rsp_bus.wz_bits;
            if (pending_commands.size() == 0) begin
               bad_beats++;
               if (bad_beats <= MAX_REPORTS)
                  $display("unexpected result beat: status %0d vx %h vy %h wz %h",
                           got.status, got.vx, got.vy, got.wz);
            end else begin
               want = pending_commands.pop_front();
               if (got.status != want.status || got.vx != want.vx ||
                   got.vy != want.vy || got.wz != want.wz) begin
                  bad_beats++;
                  if (bad_beats <= MAX_REPORTS)
                     $display("mismatch: want %0d %h %h %h, got %0d %h %h %h",
                              want.status, want.vx, want.vy, want.wz,
                              got.status, got.vx, got.vy, got.wz);
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_velocity_command_frame_parser: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int                 kind;
      int                 which;
      int                 cut;
      int                 n;
      logic [95:0]        pay;
      vcfp_pkg::byte_type h0;
      vcfp_pkg::byte_type h1;
      vcfp_pkg::byte_type chk;
      logic               flag;

      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.first_byte = 1'b0;
      rsp_bus.ready = 1'b0;

      // directed: stray byte, extreme payload, trailing byte, restart, bad header
      add_byte(8'h5A, 1'b0, 1'b0);
      pay = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'hFE, 8'h7F,
             8'h01, 8'h80, 8'hFF, 8'h00};
      add_frame(vcfp_pkg::SYNC_BYTE, vcfp_pkg::SYNC_BYTE, pay, payload_xor(pay),
                vcfp_pkg::FRAME_LEN);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_frame(vcfp_pkg::SYNC_BYTE, vcfp_pkg::SYNC_BYTE, pay, payload_xor(pay), 3);
      pay = random_payload();
      add_frame(vcfp_pkg::SYNC_BYTE, 8'hFE, pay, ~payload_xor(pay), vcfp_pkg::FRAME_LEN);

      // random: mostly well-formed frames, the rest broken frames and noise
      while (stim_items < STIM_TARGET) begin
         kind = $urandom_range(0, 99);
         pay = random_payload();
         h0 = vcfp_pkg::SYNC_BYTE;
         h1 = vcfp_pkg::SYNC_BYTE;
         chk = payload_xor(pay);
         if (kind < 60) begin
            add_frame(h0, h1, pay, chk, vcfp_pkg::FRAME_LEN);
         end else if (kind < 72) begin
            chk ^= vcfp_pkg::byte_type'($urandom_range(1, 255));
            add_frame(h0, h1, pay, chk, vcfp_pkg::FRAME_LEN);
         end else if (kind < 80) begin
            which = $urandom_range(0, 2);
            if (which != 1) h0 = vcfp_pkg::byte_type'($urandom_range(0, 254));
            if (which != 0) h1 = vcfp_pkg::byte_type'($urandom_range(0, 254));
            if ($urandom_range(0, 1)) chk = vcfp_pkg::byte_type'($urandom_range(0, 255));
            add_frame(h0, h1, pay, chk, vcfp_pkg::FRAME_LEN);
         end else if (kind < 88) begin
            cut = $urandom_range(1, vcfp_pkg::FRAME_LEN - 1);
            add_frame(h0, h1, pay, chk, cut);
         end else if (kind < 94) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
               add_byte(vcfp_pkg::byte_type'($urandom_range(0, 255)), 1'b0, 1'b0);
         end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               flag = ($urandom_range(0, 3) == 0);
               add_byte(vcfp_pkg::byte_type'($urandom_range(0, 255)), flag, flag);
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to drain and every result to arrive
      @(negedge clock);
      while (byte_queue.size() > 0 || req_bus.valid) @(negedge clock);
      while (pending_commands.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (bad_beats == 0) begin
         $display("tb_velocity_command_frame_parser: done, clean");
      end else begin
         $display("tb_velocity_command_frame_parser: done, errors");
      end
      $finish;
   end

endmodule
